// File: rtl/uart_rx_ring_fifo_assert.svh
// ----------------------------------------------------------------------------
// uart rx ring fifo assertion macros
// concurrent checks clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef UART_RX_RING_FIFO_ASSERT_SVH
`define UART_RX_RING_FIFO_ASSERT_SVH

// same-cycle implication
`define URRF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define URRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/urrf_pkg.sv
// ----------------------------------------------------------------------------
// urrf_pkg
// shared types and constants of the serial receive ring buffer
// ----------------------------------------------------------------------------
package urrf_pkg;

    localparam int DEPTH_DEFAULT = 128;
    localparam int CAP_LIMIT     = 128;
    localparam int CAP_DEFAULT   = 64;
    localparam int CFG_W         = 8;
    localparam int BYTE_W        = 8;
    localparam int COUNT_W       = 7;
    localparam int ACTION_W      = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LINE   = 2'd0,
        ACT_READ   = 2'd1,
        ACT_STATUS = 2'd2,
        ACT_FLUSH  = 2'd3
    } action_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LOAD = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                byte_present;
        logic [BYTE_W-1:0]   line_byte;
        logic                overrun_seen;
        logic                frame_seen;
    } in_item_t;

    typedef struct packed {
        logic                read_valid;
        logic [BYTE_W-1:0]   read_byte;
        logic [COUNT_W-1:0]  unread_count;
        logic                overflow_flag;
        logic                overrun_flag;
        logic                framing_flag;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_valid;
    } dp_status_t;

endpackage

// File: rtl/urrf_req_if.sv
// ----------------------------------------------------------------------------
// urrf_req_if
// request channel: one action item with its line event fields
// ----------------------------------------------------------------------------
interface urrf_req_if;
    import urrf_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                byte_present;
    logic [BYTE_W-1:0]   line_byte;
    logic                overrun_seen;
    logic                frame_seen;

    modport source (
        output valid, action, byte_present, line_byte, overrun_seen, frame_seen,
        input  ready
    );

    modport sink (
        input  valid, action, byte_present, line_byte, overrun_seen, frame_seen,
        output ready
    );

endinterface

// File: rtl/urrf_rsp_if.sv
// ----------------------------------------------------------------------------
// urrf_rsp_if
// result channel: popped byte, fill count and sticky flags
// ----------------------------------------------------------------------------
interface urrf_rsp_if;
    import urrf_pkg::*;

    logic               valid;
    logic               ready;
    logic               read_valid;
    logic [BYTE_W-1:0]  read_byte;
    logic [COUNT_W-1:0] unread_count;
    logic               overflow_flag;
    logic               overrun_flag;
    logic               framing_flag;

    modport source (
        output valid, read_valid, read_byte, unread_count,
               overflow_flag, overrun_flag, framing_flag,
        input  ready
    );

    modport sink (
        input  valid, read_valid, read_byte, unread_count,
               overflow_flag, overrun_flag, framing_flag,
        output ready
    );

endinterface

// File: rtl/urrf_ctrl.sv
// ----------------------------------------------------------------------------
// urrf_ctrl
// controller: accepts one item, then hands its result to the output register
// ----------------------------------------------------------------------------
module urrf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 rsp_ready,
    input  urrf_pkg::dp_status_t status,
    output urrf_pkg::dp_cmd_t    cmd
);
    import urrf_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        slot_free;

    assign slot_free = !status.out_valid || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.exec  = req_valid;
            end
            ST_LOAD:
            begin
                cmd.load = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/urrf_dp.sv
// ----------------------------------------------------------------------------
// urrf_dp
// datapath: ring store, pointers, sticky flags, staging and output registers
// ----------------------------------------------------------------------------
module urrf_dp #(
    parameter int RING_DEPTH = urrf_pkg::DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [urrf_pkg::CFG_W-1:0]     cfg_wdata,
    input  urrf_pkg::dp_cmd_t              cmd,
    input  urrf_pkg::in_item_t             item,
    input  logic                           rsp_ready,
    output urrf_pkg::out_item_t            result,
    output urrf_pkg::dp_status_t           status
);
    import urrf_pkg::*;

    // pointers never pass the largest legal capacity
    localparam int MEM_DEPTH = (RING_DEPTH < CAP_LIMIT) ? RING_DEPTH : CAP_LIMIT;
    localparam int PTR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CAP_W     = $clog2(MEM_DEPTH + 1);
    localparam int DEF_CAP   = (CAP_DEFAULT < MEM_DEPTH) ? CAP_DEFAULT : MEM_DEPTH;
    localparam logic [CAP_W-1:0]   DEF_CAP_V  = CAP_W'(DEF_CAP);
    localparam logic [CFG_W:0]     MEM_DEPTH_V = (CFG_W + 1)'(MEM_DEPTH);

    logic [BYTE_W-1:0] mem [MEM_DEPTH];

    logic [CAP_W-1:0]   cap_reg;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic               drop_reg, drop_next;
    logic               ovr_reg, ovr_next;
    logic               frm_reg, frm_next;
    logic               out_valid_reg, out_valid_next;

    logic               stg_valid_reg;
    logic [COUNT_W-1:0] stg_count_reg;
    logic               stg_drop_reg, stg_ovr_reg, stg_frm_reg;
    logic [BYTE_W-1:0]  rdata_reg;
    out_item_t          out_reg;

    action_t            act;
    logic [CAP_W-1:0]   wp_inc, rp_inc;
    logic [PTR_W-1:0]   wp_adv, rp_adv;
    logic               push, pop, drop, is_status;
    logic [CAP_W-1:0]   count;
    logic               cfg_bad;
    logic [CAP_W-1:0]   cap_new;

    // capacity sanitizing
    assign cfg_bad = (cfg_wdata == '0) || ({1'b0, cfg_wdata} > MEM_DEPTH_V);
    assign cap_new = cfg_bad ? DEF_CAP_V : CAP_W'(cfg_wdata);

    // pointer advance with wrap at the capacity
    assign wp_inc = CAP_W'(wp_reg) + CAP_W'(1);
    assign rp_inc = CAP_W'(rp_reg) + CAP_W'(1);
    assign wp_adv = (wp_inc >= cap_reg) ? '0 : PTR_W'(wp_inc);
    assign rp_adv = (rp_inc >= cap_reg) ? '0 : PTR_W'(rp_inc);

    assign act       = action_t'(item.action);
    assign is_status = (act == ACT_STATUS);
    assign push = (act == ACT_LINE) && item.byte_present && (wp_adv != rp_reg);
    assign drop = (act == ACT_LINE) && item.byte_present && (wp_adv == rp_reg);
    assign pop  = (act == ACT_READ) && (wp_reg != rp_reg);

    always_comb
    begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        drop_next = drop_reg;
        ovr_next  = ovr_reg;
        frm_next  = frm_reg;
        unique case (act)
            ACT_LINE:
            begin
                if (push)
                begin
                    wp_next = wp_adv;
                end
                if (drop)
                begin
                    drop_next = 1'b1;
                end
                if (item.overrun_seen)
                begin
                    ovr_next = 1'b1;
                end
                if (item.frame_seen)
                begin
                    frm_next = 1'b1;
                end
            end
            ACT_READ:
            begin
                if (pop)
                begin
                    rp_next = rp_adv;
                end
            end
            ACT_STATUS:
            begin
                drop_next = 1'b0;
                ovr_next  = 1'b0;
                frm_next  = 1'b0;
            end
            ACT_FLUSH:
            begin
                wp_next   = '0;
                rp_next   = '0;
                drop_next = 1'b0;
            end
            default:
            begin
                wp_next = wp_reg;
            end
        endcase
    end

    // fill level after this item
    assign count = (wp_next >= rp_next)
                 ? (CAP_W'(wp_next) - CAP_W'(rp_next))
                 : (cap_reg - CAP_W'(rp_next) + CAP_W'(wp_next));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= DEF_CAP_V;
            wp_reg        <= '0;
            rp_reg        <= '0;
            drop_reg      <= 1'b0;
            ovr_reg       <= 1'b0;
            frm_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg  <= cap_new;
                wp_reg   <= '0;
                rp_reg   <= '0;
                drop_reg <= 1'b0;
                ovr_reg  <= 1'b0;
                frm_reg  <= 1'b0;
            end
            else if (cmd.exec)
            begin
                wp_reg   <= wp_next;
                rp_reg   <= rp_next;
                drop_reg <= drop_next;
                ovr_reg  <= ovr_next;
                frm_reg  <= frm_next;
            end
        end
    end

    // ring store, one write or one read per item
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push)
        begin
            mem[wp_reg] <= item.line_byte;
        end
        if (cmd.exec && pop)
        begin
            rdata_reg <= mem[rp_reg];
        end
    end

    // staging and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            stg_valid_reg <= pop;
            stg_count_reg <= COUNT_W'(count);
            stg_drop_reg  <= is_status ? drop_reg : drop_next;
            stg_ovr_reg   <= is_status ? ovr_reg  : ovr_next;
            stg_frm_reg   <= is_status ? frm_reg  : frm_next;
        end
        if (cmd.load)
        begin
            out_reg.read_valid    <= stg_valid_reg;
            out_reg.read_byte     <= stg_valid_reg ? rdata_reg : '0;
            out_reg.unread_count  <= stg_count_reg;
            out_reg.overflow_flag <= stg_drop_reg;
            out_reg.overrun_flag  <= stg_ovr_reg;
            out_reg.framing_flag  <= stg_frm_reg;
        end
    end

    assign result           = out_reg;
    assign status.out_valid = out_valid_reg;

endmodule

// File: rtl/uart_rx_ring_fifo.sv
// ----------------------------------------------------------------------------
// uart_rx_ring_fifo
// serial receive ring buffer, one slot kept empty, with sticky line flags
// ----------------------------------------------------------------------------
//
// channel   dir   handshake      carries
// req       in    valid/ready    action, byte_present, line_byte, overrun_seen,
//                                frame_seen
// rsp       out   valid/ready    read_valid, read_byte, unread_count,
//                                overflow_flag, overrun_flag, framing_flag
//
// each item goes through accept then load: the accept cycle updates pointers
// and flags and does the one ring store access; the load state then moves the
// staged result (with the registered read byte) into the output register
// a result left waiting on rsp holds one finished item while the next item
// is accepted and staged; the controller stays in its load state until the
// output register frees
// rst_n clears pointers, flags, capacity (to its default) and the fsm at
// once; the ring store itself is not cleared and needs no clearing pass
// a capacity write re-initializes pointers and all three flags
//
module uart_rx_ring_fifo #(
    parameter int RING_DEPTH = urrf_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [urrf_pkg::CFG_W-1:0] cfg_wdata,
    urrf_req_if.sink                   req,
    urrf_rsp_if.source                 rsp
);
    import urrf_pkg::*;

    `include "uart_rx_ring_fifo_assert.svh"

    dp_cmd_t    cmd;
    dp_status_t status;
    in_item_t   item;
    out_item_t  result;

    // pack the request fields for the datapath
    assign item.action       = req.action;
    assign item.byte_present = req.byte_present;
    assign item.line_byte    = req.line_byte;
    assign item.overrun_seen = req.overrun_seen;
    assign item.frame_seen   = req.frame_seen;

    // controller: idle / load sequencing
    urrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: ring store, pointers, flags, result registers
    urrf_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .item      (item),
        .rsp_ready (rsp.ready),
        .result    (result),
        .status    (status)
    );

    // unpack the result onto the output channel
    assign rsp.valid         = status.out_valid;
    assign rsp.read_valid    = result.read_valid;
    assign rsp.read_byte     = result.read_byte;
    assign rsp.unread_count  = result.unread_count;
    assign rsp.overflow_flag = result.overflow_flag;
    assign rsp.overrun_flag  = result.overrun_flag;
    assign rsp.framing_flag  = result.framing_flag;

    // one item in flight: an accept is followed by a cycle without ready
    `URRF_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready,
        "item accepted while previous item still staged")

    // result transfer never overlaps an accept
    `URRF_ASSERT_NOW(a_load_vs_accept, cmd.load, !(req.valid && req.ready),
        "result load and item accept in the same cycle")

    // a result without a popped byte carries a zero byte
    `URRF_ASSERT_NOW(a_empty_byte_zero, rsp.valid && !rsp.read_valid,
        rsp.read_byte == '0, "nonzero read_byte without read_valid")

endmodule
